// ===== rtl/core/fls_pkg.sv =====
// shared types and constants for the free list slot allocator
package fls_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = 10;
    localparam int CNT_W      = 11;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type         req_type;
        logic [SLOT_W-1:0] slot_in;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        t_status           status;
    } t_res;

    typedef struct packed {
        logic              last;
        logic [SLOT_W-1:0] idx;
    } t_link;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_fls_state;

    typedef struct packed {
        logic    capture;
        logic    pop;
        logic    bump;
        logic    push;
        logic    load_out;
        t_status code;
    } t_fls_cmd;

    typedef struct packed {
        logic req_free;
        logic head_valid;
        logic top_full;
        logic slot_bad;
    } t_fls_sts;

endpackage

// ===== rtl/core/fls_ctrl.sv =====
// request sequencing state machine and output valid register
module fls_ctrl
    import fls_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_fls_sts i_sts,
    output t_fls_cmd o_cmd
);

    t_fls_state r_state;
    t_fls_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.code  = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                    if (i_sts.req_free) begin
                        if (i_sts.slot_bad) begin
                            o_cmd.code = ST_BAD;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end else if (i_sts.head_valid) begin
                        o_cmd.pop = 1'b1;
                    end else if (!i_sts.top_full) begin
                        o_cmd.bump = 1'b1;
                    end else begin
                        o_cmd.code = ST_FULL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/fls_dpath.sv =====
// link memory, free list head, bump counter and result register
module fls_dpath
    import fls_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  t_fls_cmd i_cmd,
    output t_fls_sts o_sts,
    output t_res     o_res
);

    t_link             r_link [SLOT_COUNT];
    t_link             r_rd_link;
    t_req              r_req;
    t_res              r_res;
    t_res              n_res;
    logic [SLOT_W-1:0] r_head;
    logic              r_head_valid;
    logic [CNT_W-1:0]  r_top;

    // link memory: one write, one registered read at the list head
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_link[r_req.slot_in] <= '{last: !r_head_valid, idx: r_head};
        end
        r_rd_link <= r_link[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.load_out) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_top        <= '0;
        end else begin
            if (i_cmd.pop) begin
                if (r_rd_link.last) begin
                    r_head_valid <= 1'b0;
                    r_head       <= '0;
                end else begin
                    r_head <= r_rd_link.idx;
                end
            end else if (i_cmd.push) begin
                r_head       <= r_req.slot_in;
                r_head_valid <= 1'b1;
            end
            if (i_cmd.bump) begin
                r_top <= r_top + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_res.status = i_cmd.code;
        if (i_cmd.pop) begin
            n_res.slot_out = r_head;
        end else if (i_cmd.bump) begin
            n_res.slot_out = r_top[SLOT_W-1:0];
        end else if (r_req.req_type == REQ_FREE) begin
            n_res.slot_out = r_req.slot_in;
        end else begin
            n_res.slot_out = '0;
        end
    end

    assign o_sts.req_free   = (r_req.req_type == REQ_FREE);
    assign o_sts.head_valid = r_head_valid;
    assign o_sts.top_full   = (r_top == CNT_W'(SLOT_COUNT));
    assign o_sts.slot_bad   = ({1'b0, r_req.slot_in} >= r_top);
    assign o_res            = r_res;

endmodule

// ===== rtl/core/free_list_slot_allocator.sv =====
// top level of the linked free list slot allocator
//
//   channel  direction  payload  handshake
//   in       input      t_req    i_in_valid / o_in_stall
//   out      output     t_res    o_out_valid / i_out_stall
//
// each request is captured in S_IDLE while the link memory read of the list
// head completes; S_EXEC then updates the list and loads the result
// the capture step covers the registered read port of the link memory
// a result waits in the output register; a new request is taken meanwhile and
// holds in S_EXEC only while that register is still stalled
// reset empties the free list and clears the bump counter; no clearing pass
module free_list_slot_allocator
    import fls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_res
);

    t_fls_cmd cmd;
    t_fls_sts sts;

    fls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fls_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_out_res)
    );

endmodule
